[src/palette_gradient_builder_top_macros.svh]
// Assertion macros for the checker file of the palette ramp builder.
`ifndef PALETTE_GRADIENT_BUILDER_TOP_MACROS_SVH
`define PALETTE_GRADIENT_BUILDER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PGB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pgb check failed");

// Consequent must hold in the cycle after the antecedent.
`define PGB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgb check failed");

`endif

[src/pgb_pkg.sv]
package pgb_pkg;

    // Palette and set geometry.
    localparam int SET_COUNT     = 16;
    localparam int SET_W         = $clog2(SET_COUNT);
    localparam int PALETTE_DEPTH = 256;
    localparam int WP_W          = $clog2(PALETTE_DEPTH + 1);
    localparam int IDX_W         = 8;
    localparam int CNT_W         = 9;

    // Ramp length handling.
    localparam int MAX_RAMP  = 64;
    localparam int LEN_W     = $clog2(MAX_RAMP);
    localparam int IN_LEN_W  = 7;

    // Color channels and the step divider.
    localparam int COLOR_W    = 8;
    localparam int LANES      = 3;
    localparam int STEP_W     = COLOR_W + 2;
    localparam int DIV_STEPS  = COLOR_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    // Command queue depth.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Result status codes.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SHORT = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Lane 2 is red, lane 1 green, lane 0 blue.
    typedef logic [LANES-1:0][COLOR_W-1:0] rgb_t;
    typedef logic [LANES-1:0][STEP_W-1:0]  step_t;

    typedef enum logic [1:0] {
        CMD_SINGLE,
        CMD_SHORT,
        CMD_RAMP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [SET_W-1:0] set;
        logic [LEN_W-1:0] len_m1;
        rgb_t             color;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_RAMP
    } back_state_t;

endpackage

[src/pgb_front.sv]
module pgb_front (
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [pgb_pkg::SET_W-1:0]     set_number,
    input  logic [pgb_pkg::IN_LEN_W-1:0]  ramp_length,
    input  logic [pgb_pkg::COLOR_W-1:0]   red_in,
    input  logic [pgb_pkg::COLOR_W-1:0]   green_in,
    input  logic [pgb_pkg::COLOR_W-1:0]   blue_in,
    output logic                          push_valid,
    input  logic                          push_ready,
    output pgb_pkg::cmd_t                 push_data
);
    import pgb_pkg::*;

    logic [IN_LEN_W-1:0] len_m1_full;

    // A word enters whenever the queue has room.
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // Saturate the ramp length and keep the divisor (length minus one).
    always_comb
    begin
        if (ramp_length > IN_LEN_W'(MAX_RAMP))
        begin
            len_m1_full = IN_LEN_W'(MAX_RAMP - 1);
        end
        else
        begin
            len_m1_full = ramp_length - 1'b1;
        end
    end

    // Classify the command.
    always_comb
    begin
        push_data.set    = set_number;
        push_data.len_m1 = len_m1_full[LEN_W-1:0];
        push_data.color  = {red_in, green_in, blue_in};
        if (!func)
        begin
            push_data.kind = CMD_SINGLE;
        end
        else if (ramp_length < IN_LEN_W'(2))
        begin
            push_data.kind = CMD_SHORT;
        end
        else
        begin
            push_data.kind = CMD_RAMP;
        end
    end

endmodule

[src/pgb_cmd_fifo.sv]
module pgb_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  pgb_pkg::cmd_t push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output pgb_pkg::cmd_t pop_data
);
    import pgb_pkg::*;

    cmd_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               push_fire;
    logic               pop_fire;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop_fire && !push_fire)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push_fire)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/pgb_div.sv]
module pgb_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  pgb_pkg::rgb_t              base,
    input  pgb_pkg::rgb_t              target,
    input  logic [pgb_pkg::LEN_W-1:0]  divisor,
    output logic                       done,
    output pgb_pkg::step_t             step
);
    import pgb_pkg::*;

    logic [LANES-1:0][LEN_W-1:0]   rem_reg;
    logic [LANES-1:0][COLOR_W-1:0] quo_reg;
    logic [LANES-1:0]              neg_reg;
    logic [LEN_W-1:0]              divisor_reg;
    logic [DIV_CNT_W-1:0]          cnt_reg;
    logic                          busy_reg;
    logic                          done_reg;

    logic [LANES-1:0][LEN_W:0]     trial;
    logic [LANES-1:0][LEN_W:0]     diff;
    logic [LANES-1:0][LEN_W-1:0]   rem_next;
    logic [LANES-1:0][COLOR_W-1:0] quo_next;
    logic [LANES-1:0][STEP_W-1:0]  quo_ext;

    assign done = done_reg;

    // One restoring-division bit per cycle in each channel lane.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            trial[i] = {rem_reg[i], quo_reg[i][COLOR_W-1]};
            diff[i]  = trial[i] - {1'b0, divisor_reg};
            if (trial[i] >= {1'b0, divisor_reg})
            begin
                rem_next[i] = diff[i][LEN_W-1:0];
                quo_next[i] = {quo_reg[i][COLOR_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][LEN_W-1:0];
                quo_next[i] = {quo_reg[i][COLOR_W-2:0], 1'b0};
            end
        end
    end

    // Apply the sign of the difference to the quotient magnitude.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            quo_ext[i] = {2'b00, quo_reg[i]};
            step[i]    = neg_reg[i] ? (~quo_ext[i] + 1'b1) : quo_ext[i];
        end
    end

    // Sequencing of the iterations.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand load and shift.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            for (int i = 0; i < LANES; i++)
            begin
                rem_reg[i] <= '0;
                if (target[i] >= base[i])
                begin
                    quo_reg[i] <= target[i] - base[i];
                    neg_reg[i] <= 1'b0;
                end
                else
                begin
                    quo_reg[i] <= base[i] - target[i];
                    neg_reg[i] <= 1'b1;
                end
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

endmodule

[src/pgb_back.sv]
module pgb_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  pgb_pkg::cmd_t                pop_data,
    output logic                         div_start,
    output pgb_pkg::rgb_t                div_base,
    output pgb_pkg::rgb_t                div_target,
    output logic [pgb_pkg::LEN_W-1:0]    div_divisor,
    input  logic                         div_done,
    input  pgb_pkg::step_t               div_step,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [pgb_pkg::IDX_W-1:0]    palette_index,
    output logic [pgb_pkg::COLOR_W-1:0]  red_out,
    output logic [pgb_pkg::COLOR_W-1:0]  green_out,
    output logic [pgb_pkg::COLOR_W-1:0]  blue_out,
    output logic [pgb_pkg::SET_W-1:0]    owner_set,
    output logic [pgb_pkg::IDX_W-1:0]    owner_start,
    output logic [pgb_pkg::CNT_W-1:0]    owner_count,
    output logic [1:0]                   status,
    output logic                         last_of_run
);
    import pgb_pkg::*;

    // Control state.
    back_state_t      state_reg;
    back_state_t      state_next;
    logic [WP_W-1:0]  wp_reg;
    rgb_t             last_color_reg;
    logic [CNT_W-1:0] set_count_reg [SET_COUNT];
    logic [IDX_W-1:0] set_first_reg [SET_COUNT];
    logic [LEN_W-1:0] k_reg;
    logic             out_valid_reg;

    // Payload state.
    cmd_t             cmd_reg;
    step_t            step_reg;
    rgb_t             acc_reg;
    logic [IDX_W-1:0] index_out_reg;
    rgb_t             color_out_reg;
    logic [SET_W-1:0] set_out_reg;
    logic [IDX_W-1:0] start_out_reg;
    logic [CNT_W-1:0] count_out_reg;
    logic [1:0]       status_out_reg;
    logic             last_out_reg;

    // Issue decisions.
    logic             slot_free;
    logic             pop_fire;
    logic             ramp_final;
    logic             issue_valid;
    logic             issue_write;
    logic             issue_last;
    logic [SET_W-1:0] issue_set;
    rgb_t             issue_color;
    step_t            ramp_wide;
    rgb_t             ramp_next;

    // Bookkeeping lookups.
    logic [CNT_W-1:0] cnt_cur;
    logic [IDX_W-1:0] first_cur;
    logic [CNT_W-1:0] cnt_new;
    logic [IDX_W-1:0] first_new;
    logic             pal_full;
    logic             do_write;

    assign slot_free   = !out_valid_reg || out_ready;
    assign pop_fire    = pop_valid && pop_ready;
    assign ramp_final  = (k_reg == cmd_reg.len_m1);
    assign div_base    = last_color_reg;
    assign div_target  = pop_data.color;
    assign div_divisor = pop_data.len_m1;

    // Next ramp entry in each lane: previous entry plus the signed step.
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ramp_wide[i] = {2'b00, acc_reg[i]} + step_reg[i];
            ramp_next[i] = ramp_wide[i][COLOR_W-1:0];
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (pop_fire && (pop_data.kind == CMD_RAMP))
                begin
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (div_done)
                begin
                    state_next = BK_RAMP;
                end
            end
            BK_RAMP:
            begin
                if (slot_free && ramp_final)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // State outputs: queue pop, divider start and the result to issue.
    always_comb
    begin
        pop_ready   = 1'b0;
        div_start   = 1'b0;
        issue_valid = 1'b0;
        issue_write = 1'b0;
        issue_last  = 1'b0;
        issue_set   = cmd_reg.set;
        issue_color = cmd_reg.color;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready   = slot_free;
                issue_set   = pop_data.set;
                issue_color = pop_data.color;
                if (pop_valid && slot_free)
                begin
                    case (pop_data.kind)
                        CMD_SINGLE:
                        begin
                            issue_valid = 1'b1;
                            issue_write = 1'b1;
                            issue_last  = 1'b1;
                        end
                        CMD_SHORT:
                        begin
                            issue_valid = 1'b1;
                            issue_last  = 1'b1;
                        end
                        CMD_RAMP:
                        begin
                            div_start = 1'b1;
                        end
                        default:
                        begin
                            issue_valid = 1'b0;
                        end
                    endcase
                end
            end
            BK_RAMP:
            begin
                if (slot_free)
                begin
                    issue_valid = 1'b1;
                    issue_write = 1'b1;
                    issue_last  = ramp_final;
                    issue_color = ramp_final ? cmd_reg.color : ramp_next;
                end
            end
            default:
            begin
                issue_valid = 1'b0;
            end
        endcase
    end

    // Set bookkeeping for the entry being issued.
    always_comb
    begin
        cnt_cur   = set_count_reg[issue_set];
        first_cur = set_first_reg[issue_set];
        cnt_new   = cnt_cur + 1'b1;
        first_new = (cnt_cur == '0) ? wp_reg[IDX_W-1:0] : first_cur;
        pal_full  = (wp_reg >= WP_W'(PALETTE_DEPTH));
        do_write  = issue_valid && issue_write && !pal_full;
    end

    // Control registers and palette bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            wp_reg         <= '0;
            last_color_reg <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            for (int s = 0; s < SET_COUNT; s++)
            begin
                set_count_reg[s] <= '0;
                set_first_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (issue_valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (do_write)
            begin
                wp_reg                   <= wp_reg + 1'b1;
                last_color_reg           <= issue_color;
                set_count_reg[issue_set] <= cnt_new;
                set_first_reg[issue_set] <= first_new;
            end
            if ((state_reg == BK_DIV) && div_done)
            begin
                k_reg <= '0;
            end
            else if ((state_reg == BK_RAMP) && slot_free)
            begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // Command, ramp accumulators and the output word.
    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            cmd_reg <= pop_data;
        end
        if ((state_reg == BK_DIV) && div_done)
        begin
            step_reg <= div_step;
            acc_reg  <= last_color_reg;
        end
        else if ((state_reg == BK_RAMP) && slot_free)
        begin
            acc_reg <= ramp_next;
        end
        if (issue_valid)
        begin
            set_out_reg  <= issue_set;
            last_out_reg <= issue_last;
            if (!issue_write)
            begin
                index_out_reg  <= '0;
                color_out_reg  <= '0;
                start_out_reg  <= first_cur;
                count_out_reg  <= cnt_cur;
                status_out_reg <= STATUS_SHORT;
            end
            else if (pal_full)
            begin
                index_out_reg  <= '0;
                color_out_reg  <= issue_color;
                start_out_reg  <= first_cur;
                count_out_reg  <= cnt_cur;
                status_out_reg <= STATUS_FULL;
            end
            else
            begin
                index_out_reg  <= wp_reg[IDX_W-1:0];
                color_out_reg  <= issue_color;
                start_out_reg  <= first_new;
                count_out_reg  <= cnt_new;
                status_out_reg <= STATUS_OK;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign palette_index = index_out_reg;
    assign red_out       = color_out_reg[2];
    assign green_out     = color_out_reg[1];
    assign blue_out      = color_out_reg[0];
    assign owner_set     = set_out_reg;
    assign owner_start   = start_out_reg;
    assign owner_count   = count_out_reg;
    assign status        = status_out_reg;
    assign last_of_run   = last_out_reg;

endmodule

[src/palette_gradient_builder_top.sv]
// Channel   Handshake                 Word
// --------  ------------------------  ---------------------------------------------
// input     in_valid / in_ready       func, set_number, ramp_length, RGB color
// output    out_valid / out_ready     index, RGB, owner set/start/count, status, last
//
// A command enters a two-deep queue; the executor takes the next one when it is
// idle and its output register is free. A single color or a too-short ramp yields
// its result in the cycle after it is dequeued. A ramp first runs the serial step
// divider (dequeue and start, one quotient bit per cycle, then the step hand-off)
// and then issues its n entries, one per free output slot.
// Reset clears the write pointer, the last color and all set bookkeeping at once.
// A stalled output holds its word; the queue keeps accepting until it is full.
module palette_gradient_builder_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic [pgb_pkg::SET_W-1:0]     set_number,
    input  logic [pgb_pkg::IN_LEN_W-1:0]  ramp_length,
    input  logic [pgb_pkg::COLOR_W-1:0]   red_in,
    input  logic [pgb_pkg::COLOR_W-1:0]   green_in,
    input  logic [pgb_pkg::COLOR_W-1:0]   blue_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pgb_pkg::IDX_W-1:0]     palette_index,
    output logic [pgb_pkg::COLOR_W-1:0]   red_out,
    output logic [pgb_pkg::COLOR_W-1:0]   green_out,
    output logic [pgb_pkg::COLOR_W-1:0]   blue_out,
    output logic [pgb_pkg::SET_W-1:0]     owner_set,
    output logic [pgb_pkg::IDX_W-1:0]     owner_start,
    output logic [pgb_pkg::CNT_W-1:0]     owner_count,
    output logic [1:0]                    status,
    output logic                          last_of_run
);
    import pgb_pkg::*;

    logic             push_valid;
    logic             push_ready;
    cmd_t             push_data;
    logic             pop_valid;
    logic             pop_ready;
    cmd_t             pop_data;
    logic             div_start;
    rgb_t             div_base;
    rgb_t             div_target;
    logic [LEN_W-1:0] div_divisor;
    logic             div_done;
    step_t            div_step;

    // Front: accept and classify commands.
    pgb_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .set_number  (set_number),
        .ramp_length (ramp_length),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_data   (push_data)
    );

    // Queue between front and executor.
    pgb_cmd_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // Serial divider for the per-channel ramp step.
    pgb_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .base    (div_base),
        .target  (div_target),
        .divisor (div_divisor),
        .done    (div_done),
        .step    (div_step)
    );

    // Executor: palette bookkeeping and result generation.
    pgb_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .div_start     (div_start),
        .div_base      (div_base),
        .div_target    (div_target),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_step      (div_step),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .palette_index (palette_index),
        .red_out       (red_out),
        .green_out     (green_out),
        .blue_out      (blue_out),
        .owner_set     (owner_set),
        .owner_start   (owner_start),
        .owner_count   (owner_count),
        .status        (status),
        .last_of_run   (last_of_run)
    );

endmodule

[src/pgb_checker.sv]
`include "palette_gradient_builder_top_macros.svh"

module pgb_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [pgb_pkg::IDX_W-1:0]     palette_index,
    input logic [pgb_pkg::COLOR_W-1:0]   red_out,
    input logic [pgb_pkg::COLOR_W-1:0]   green_out,
    input logic [pgb_pkg::COLOR_W-1:0]   blue_out,
    input logic [pgb_pkg::CNT_W-1:0]     owner_count,
    input logic [1:0]                    status,
    input logic                          last_of_run
);
    import pgb_pkg::*;

    // A stalled output word keeps its contents.
    `PGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(palette_index) && $stable(status) && $stable(last_of_run))

    // Results that write nothing report index zero.
    `PGB_ASSERT_NOW(a_nowrite_index, out_valid && (status != STATUS_OK), palette_index == '0)

    // A rejected short ramp is a single, colorless, final result.
    `PGB_ASSERT_NOW(a_short_form, out_valid && (status == STATUS_SHORT), last_of_run && (red_out == '0) && (green_out == '0) && (blue_out == '0))

    // A written entry always leaves its set non-empty.
    `PGB_ASSERT_NOW(a_written_count, out_valid && (status == STATUS_OK), owner_count != '0)

endmodule

bind palette_gradient_builder_top pgb_checker u_checker (.*);
